>>> hdl/bush_mosteller_cue_learner_core_assert.svh
// ----------------------------------------------------------------------------
// Assertion macros used by the checker file of the cue learner
// ----------------------------------------------------------------------------
`ifndef BUSH_MOSTELLER_CUE_LEARNER_CORE_ASSERT_SVH
`define BUSH_MOSTELLER_CUE_LEARNER_CORE_ASSERT_SVH

// same-cycle implication, disabled while reset is low
`define BMCL_ASSERT_SAME(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, disabled while reset is low
`define BMCL_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> hdl/bmcl_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bmcl_pkg
// Types and constants of the cue learner: field widths, mode and register
// codes, lane control bundle.
// ----------------------------------------------------------------------------
package bmcl_pkg;

    localparam int MAX_CUES   = 4;
    localparam int W_DATA     = 16;
    localparam int W_LR       = 15;
    localparam int W_SUM      = 18;
    localparam int W_PROD     = 21;   // rounded product, Q8.12 plus guard
    localparam int W_CFG_IDX  = 3;
    localparam int W_MODE     = 2;

    localparam logic [W_MODE-1:0] MODE_RELOAD = 2'd1;
    localparam logic [W_MODE-1:0] MODE_FREEZE = 2'd2;

    localparam logic [W_CFG_IDX-1:0] REG_LEARNING_RATE  = 3'd0;
    localparam logic [W_CFG_IDX-1:0] REG_INIT_WEIGHT_0  = 3'd1;

    localparam logic [W_LR-1:0] LR_RESET = 15'd410;

    typedef logic signed [W_DATA-1:0] data_t;
    typedef logic signed [W_PROD-1:0] prod_t;

    // per-trial control strobes from the sequencer to every lane
    typedef struct packed {
        logic load;     // input beat taken, capture activation
        logic reload;   // restore configured weight on load
        logic prod;     // x * w
        logic delta;    // lr * (lambda - a)
        logic upd;      // w + d * x
        logic freeze;   // keep weight on upd
    } bmcl_ctrl_t;

    typedef enum logic [4:0] {
        ST_IDLE  = 5'b00001,
        ST_PROD  = 5'b00010,
        ST_DELTA = 5'b00100,
        ST_UPD   = 5'b01000,
        ST_OUT   = 5'b10000
    } bmcl_state_t;

endpackage

>>> hdl/bmcl_lane.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bmcl_lane
// One cue: holds its weight, forms the rounded activation, the learning
// step and the updated weight over three multiply steps.
// ----------------------------------------------------------------------------
module bmcl_lane
    import bmcl_pkg::*;
(
    input  logic             aclk,
    input  logic             aresetn,
    input  bmcl_ctrl_t       ctrl,
    input  data_t            x_in,
    input  data_t            lambda,
    input  logic [W_LR-1:0]  lr,
    input  data_t            init_weight,
    output prod_t            act_out,
    output data_t            weight_out
);

    // round half up of v / 4096
    function automatic prod_t rnd12(input logic signed [32:0] v);
        logic signed [32:0] t;
        begin
            t = (v + 33'sd2048) >>> 12;
            rnd12 = t[W_PROD-1:0];
        end
    endfunction

    function automatic data_t sat16(input logic signed [21:0] v);
        begin
            if (v > 22'sd32767)
                sat16 = 16'sh7FFF;
            else if (v < -22'sd32768)
                sat16 = 16'sh8000;
            else
                sat16 = v[W_DATA-1:0];
        end
    endfunction

    data_t x_reg;
    data_t weight_reg;
    prod_t act_reg;
    data_t step_reg;

    logic signed [31:0] xw_prod;
    logic signed [21:0] err_wide;
    data_t              err;
    logic signed [31:0] lr_prod;
    logic signed [31:0] dx_prod;
    logic signed [21:0] w_sum;
    data_t              weight_next;

    assign xw_prod  = x_reg * weight_reg;
    assign err_wide = 22'(lambda) - 22'(act_reg);
    assign err      = sat16(err_wide);
    assign lr_prod  = $signed({1'b0, lr}) * err;
    assign dx_prod  = step_reg * x_reg;
    assign w_sum    = 22'(weight_reg) + 22'(rnd12(33'(dx_prod)));

    always_comb begin
        weight_next = weight_reg;
        if (ctrl.load && ctrl.reload)
            weight_next = init_weight;
        else if (ctrl.upd && !ctrl.freeze)
            weight_next = sat16(w_sum);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            weight_reg <= '0;
        end else begin
            weight_reg <= weight_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (ctrl.load)
            x_reg <= x_in;
        if (ctrl.prod)
            act_reg <= rnd12(33'(xw_prod));
        if (ctrl.delta)
            step_reg <= sat16(22'(rnd12(33'(lr_prod))));
    end

    assign act_out    = act_reg;
    assign weight_out = weight_reg;

endmodule

>>> hdl/bmcl_merge.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bmcl_merge
// Adds the lanes' rounded activations and saturates to the 18-bit result.
// ----------------------------------------------------------------------------
module bmcl_merge
    import bmcl_pkg::*;
#(
    parameter int NUM_CUES = 4
) (
    input  logic               aclk,
    input  logic               en,
    input  prod_t              act [NUM_CUES],
    output logic [W_SUM-1:0]   sum_out
);

    localparam int W_ACC = W_PROD + 2;

    logic signed [W_ACC-1:0] acc;
    logic [W_SUM-1:0]        sum_reg;
    logic [W_SUM-1:0]        sum_next;

    always_comb begin
        acc = '0;
        for (int k = 0; k < NUM_CUES; k++)
            acc = acc + W_ACC'(act[k]);
        if (acc > W_ACC'(131071))
            sum_next = 18'h1FFFF;
        else if (acc < -W_ACC'(131072))
            sum_next = 18'h20000;
        else
            sum_next = acc[W_SUM-1:0];
    end

    always_ff @(posedge aclk) begin
        if (en)
            sum_reg <= sum_next;
    end

    assign sum_out = sum_reg;

endmodule

>>> hdl/bush_mosteller_cue_learner_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bush_mosteller_cue_learner_core
// Per-cue weight learner: saturated weighted sum of cue activations and a
// delta-rule weight update, one lane per cue, signed Q4.12 arithmetic.
// ----------------------------------------------------------------------------
// channel  | dir | beat contents (lowest bits first)
// s_axis   | in  | mode, target_level, cue_activation_0..3
// m_axis   | out | summed_output, new_weight_0..3
// cfg      | in  | register index, write data; no read-back
//
// A trial runs through x*w, lr*error, weight update and output load; the
// three dependent multiplies in each lane set that sequence of steps.
// The next beat is taken in the output-load cycle when the result register
// is free; a stalled result holds the block after its update.
// Reset (synchronous, active low) restores control state, configuration and weights to defaults.
// ----------------------------------------------------------------------------
module bush_mosteller_cue_learner_core
    import bmcl_pkg::*;
#(
    parameter int NUM_CUES = 4
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    // mode[1:0], target_level[17:2], cue_activation_0..3 [81:18], zero pad
    input  logic [87:0]           s_tdata,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    // summed_output[17:0], new_weight_0..3 [81:18], zero pad
    output logic [87:0]           m_tdata,
    output logic                  m_tvalid,
    input  logic                  m_tready,
    input  logic                  cfg_wr_en,
    input  logic [W_CFG_IDX-1:0]  cfg_index,
    input  logic [W_DATA-1:0]     cfg_wr_data
);

    localparam int X_LSB = W_MODE + W_DATA;

    bmcl_state_t state_reg, state_next;

    logic [W_LR-1:0]   lr_reg;
    data_t             init_w_reg [NUM_CUES];
    logic [W_MODE-1:0] mode_reg;
    data_t             lambda_reg;
    logic              m_tvalid_reg, m_tvalid_next;
    logic [87:0]       m_tdata_reg;

    logic              s_accept;
    logic              out_free;
    bmcl_ctrl_t        ctrl;
    prod_t             act [NUM_CUES];
    data_t             weight [MAX_CUES];
    logic [W_SUM-1:0]  sum;

    assign out_free = !m_tvalid_reg || m_tready;
    assign s_tready = (state_reg == ST_IDLE) || ((state_reg == ST_OUT) && out_free);
    assign s_accept = s_tvalid && s_tready;

    always_comb begin
        ctrl.load   = s_accept;
        ctrl.reload = (s_tdata[W_MODE-1:0] == MODE_RELOAD);
        ctrl.prod   = (state_reg == ST_PROD);
        ctrl.delta  = (state_reg == ST_DELTA);
        ctrl.upd    = (state_reg == ST_UPD);
        ctrl.freeze = (mode_reg == MODE_FREEZE);
    end

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:  if (s_accept) state_next = ST_PROD;
            ST_PROD:  state_next = ST_DELTA;
            ST_DELTA: state_next = ST_UPD;
            ST_UPD:   state_next = ST_OUT;
            ST_OUT: begin
                if (out_free)
                    state_next = s_accept ? ST_PROD : ST_IDLE;
            end
            default:  state_next = ST_IDLE;
        endcase
    end

    always_comb begin
        m_tvalid_next = m_tvalid_reg;
        if ((state_reg == ST_OUT) && out_free)
            m_tvalid_next = 1'b1;
        else if (m_tready)
            m_tvalid_next = 1'b0;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            m_tvalid_reg <= 1'b0;
            lr_reg       <= LR_RESET;
            for (int k = 0; k < NUM_CUES; k++)
                init_w_reg[k] <= '0;
        end else begin
            state_reg    <= state_next;
            m_tvalid_reg <= m_tvalid_next;
            if (cfg_wr_en) begin
                if (cfg_index == REG_LEARNING_RATE)
                    lr_reg <= cfg_wr_data[W_LR-1:0];
                for (int k = 0; k < NUM_CUES; k++)
                    if (cfg_index == W_CFG_IDX'(REG_INIT_WEIGHT_0 + k))
                        init_w_reg[k] <= cfg_wr_data;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_accept) begin
            mode_reg   <= s_tdata[W_MODE-1:0];
            lambda_reg <= s_tdata[X_LSB-1:W_MODE];
        end
        if ((state_reg == ST_OUT) && out_free) begin
            m_tdata_reg <= {6'd0, weight[3], weight[2], weight[1], weight[0], sum};
        end
    end

    genvar g;
    generate
        for (g = 0; g < MAX_CUES; g++) begin : g_lane
            if (g < NUM_CUES) begin : g_on
                bmcl_lane u_lane (
                    .aclk        (aclk),
                    .aresetn     (aresetn),
                    .ctrl        (ctrl),
                    .x_in        (s_tdata[X_LSB + g*W_DATA +: W_DATA]),
                    .lambda      (lambda_reg),
                    .lr          (lr_reg),
                    .init_weight (init_w_reg[g]),
                    .act_out     (act[g]),
                    .weight_out  (weight[g])
                );
            end else begin : g_off
                assign weight[g] = '0;
            end
        end
    endgenerate

    bmcl_merge #(
        .NUM_CUES (NUM_CUES)
    ) u_merge (
        .aclk    (aclk),
        .en      (ctrl.delta),
        .act     (act),
        .sum_out (sum)
    );

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

endmodule

>>> hdl/bmcl_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bmcl_checker
// Port-level checks of the cue learner, bound to the top level.
// ----------------------------------------------------------------------------
`include "bush_mosteller_cue_learner_core_assert.svh"

module bmcl_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        s_tvalid,
    input logic        s_tready,
    input logic [87:0] m_tdata,
    input logic        m_tvalid,
    input logic        m_tready
);

    // a stalled result beat holds its data
    `BMCL_ASSERT_NEXT(a_out_hold, aclk, aresetn, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata), "result beat changed while stalled")

    // a trial keeps the input closed through its product, delta and update states
    `BMCL_ASSERT_NEXT(a_busy, aclk, aresetn, s_tvalid && s_tready, !s_tready ##1 !s_tready ##1 !s_tready, "input reopened during a trial")

    // a new result only follows the update cycle, when the input is closed
    `BMCL_ASSERT_SAME(a_out_origin, aclk, aresetn, $rose(m_tvalid), $past(!s_tready, 2), "result without a preceding update")

    // no result beat right out of reset
    `BMCL_ASSERT_SAME(a_rst_quiet, aclk, aresetn, $rose(aresetn), !m_tvalid, "result valid out of reset")

endmodule

bind bush_mosteller_cue_learner_core bmcl_checker u_bmcl_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tdata  (m_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready)
);

>>> tb/sv/tb_bush_mosteller_cue_learner_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_bush_mosteller_cue_learner_core
// Self-checking bench for the cue learner. A directed table (extremes, every
// mode, register writes, ignored register indexes) is followed by random
// trials under changing learning rates and initial weights. Each trial taken
// on the input stream is run through a cycle-free model of the weight rule
// and the result beat on the output stream is compared field by field.
// ----------------------------------------------------------------------------
module tb_bush_mosteller_cue_learner_core;
    import bmcl_pkg::*;

    localparam int          CUES          = 4;
    localparam int          SETTLE_CYCLES = 10;
    localparam int          LIMIT_CYCLES  = 400000;
    localparam int          SEG_TRIALS    = 100;
    localparam int          SEGS_PER_PASS = 3;

    localparam logic [W_MODE-1:0]    MODE_LEARN     = 2'd0;
    localparam logic [W_MODE-1:0]    MODE_LEARN_ALT = 2'd3;   // decoded as plain learning

    localparam logic [W_CFG_IDX-1:0] REG_INIT_WEIGHT_1 = REG_INIT_WEIGHT_0 + 3'd1;
    localparam logic [W_CFG_IDX-1:0] REG_INIT_WEIGHT_2 = REG_INIT_WEIGHT_0 + 3'd2;
    localparam logic [W_CFG_IDX-1:0] REG_INIT_WEIGHT_3 = REG_INIT_WEIGHT_0 + 3'd3;
    localparam logic [W_CFG_IDX-1:0] REG_UNUSED_5      = REG_INIT_WEIGHT_0 + 3'd4;
    localparam logic [W_CFG_IDX-1:0] REG_UNUSED_6      = REG_INIT_WEIGHT_0 + 3'd5;
    localparam logic [W_CFG_IDX-1:0] REG_UNUSED_7      = REG_INIT_WEIGHT_0 + 3'd6;

    typedef struct {
        logic [W_MODE-1:0] mode;
        data_t             target;
        data_t             cue [CUES];
    } trial_t;

    typedef struct {
        logic signed [W_SUM-1:0] sum;
        data_t                   w [CUES];
    } outcome_t;

    typedef enum logic {ROW_TRIAL, ROW_REG} row_kind_e;

    typedef struct {
        row_kind_e            kind;
        trial_t               trial;
        bit                   known;     // outcome typed in below
        outcome_t             outcome;
        logic [W_CFG_IDX-1:0] reg_idx;
        logic [W_DATA-1:0]    reg_data;
    } dir_row_t;

    localparam trial_t   ZERO_TRIAL   = '{MODE_LEARN, 0, '{0, 0, 0, 0}};
    localparam outcome_t ZERO_OUTCOME = '{0, '{0, 0, 0, 0}};
    localparam int       N_DIR        = 28;

    logic                 aclk;
    logic                 aresetn;
    logic [87:0]          s_tdata;
    logic                 s_tvalid;
    logic                 s_tready;
    logic [87:0]          m_tdata;
    logic                 m_tvalid;
    logic                 m_tready;
    logic                 cfg_wr_en;
    logic [W_CFG_IDX-1:0] cfg_index;
    logic [W_DATA-1:0]    cfg_wr_data;

    // model state
    logic [W_LR-1:0] lr_model;
    data_t           init_w_model [CUES];
    data_t           weights_model [CUES];

    outcome_t pending_outcomes [$];
    int       mismatch_count;
    int       cycle_count;
    int       src_idle_pct;
    int       sink_stall_pct;

    bush_mosteller_cue_learner_core i_dut (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_tdata     (s_tdata),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .m_tdata     (m_tdata),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_index   (cfg_index),
        .cfg_wr_data (cfg_wr_data)
    );

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    // ------------------------------------------------------------------------
    // weight rule
    // ------------------------------------------------------------------------
    // round half up of v / 2^12
    function automatic longint round_q12(input longint v);
        return (v + 64'sd2048) >>> 12;
    endfunction

    function automatic longint clamp(input longint v, input int bits);
        longint hi;
        longint lo;
        hi = (longint'(1) <<< (bits - 1)) - 1;
        lo = -hi - 1;
        if (v > hi) return hi;
        if (v < lo) return lo;
        return v;
    endfunction

    function automatic outcome_t predict_trial(input trial_t t);
        outcome_t o;
        longint   acc;
        longint   x;
        longint   w;
        longint   a;
        longint   err;
        longint   step;
        if (t.mode == MODE_RELOAD) begin
            for (int k = 0; k < CUES; k++) weights_model[k] = init_w_model[k];
        end
        acc = 0;
        for (int k = 0; k < CUES; k++) begin
            x    = longint'(t.cue[k]);
            w    = longint'(weights_model[k]);
            a    = round_q12(x * w);
            err  = clamp(longint'(t.target) - a, W_DATA);
            step = clamp(round_q12(longint'(lr_model) * err), W_DATA);
            acc += a;
            if (t.mode != MODE_FREEZE) begin
                weights_model[k] = data_t'(clamp(w + round_q12(step * x), W_DATA));
            end
            o.w[k] = weights_model[k];
        end
        o.sum = W_SUM'(clamp(acc, W_SUM));
        return o;
    endfunction

    function automatic data_t rand_q412();
        case ($urandom_range(7))
            0:       return 16'sh7FFF;
            1:       return 16'sh8000;
            2:       return 16'sh0000;
            3, 4, 5: return data_t'($signed($urandom_range(16384)) - 8192);
            default: return data_t'($urandom);
        endcase
    endfunction

    // ------------------------------------------------------------------------
    // drivers (all inputs change on the falling edge)
    // ------------------------------------------------------------------------
    task automatic write_reg(input logic [W_CFG_IDX-1:0] idx, input logic [W_DATA-1:0] data);
        cfg_wr_en   = 1'b1;
        cfg_index   = idx;
        cfg_wr_data = data;
        @(negedge aclk);
        cfg_wr_en   = 1'b0;
        if (idx == REG_LEARNING_RATE) begin
            lr_model = data[W_LR-1:0];
        end else if (idx >= REG_INIT_WEIGHT_0 && idx <= REG_INIT_WEIGHT_3) begin
            init_w_model[idx - REG_INIT_WEIGHT_0] = data_t'(data);
        end
    endtask

    // holds off the sender until every result is back and the block is idle
    task automatic drain_results();
        s_tvalid = 1'b0;
        while (pending_outcomes.size() != 0) @(negedge aclk);
        repeat (SETTLE_CYCLES) @(negedge aclk);
    endtask

    task automatic send_trial(input trial_t t, input bit known, input outcome_t typed);
        outcome_t predicted;
        while (src_idle_pct > 0 && $urandom_range(99) < src_idle_pct) begin
            s_tvalid = 1'b0;
            @(negedge aclk);
        end
        s_tvalid = 1'b1;
        s_tdata  = {6'd0, t.cue[3], t.cue[2], t.cue[1], t.cue[0], t.target, t.mode};
        do @(posedge aclk); while (!s_tready);
        predicted = predict_trial(t);
        pending_outcomes.push_back(known ? typed : predicted);
        @(negedge aclk);
    endtask

    // ------------------------------------------------------------------------
    // result side
    // ------------------------------------------------------------------------
    initial begin
        m_tready = 1'b0;
        forever begin
            @(negedge aclk);
            m_tready = (sink_stall_pct == 0) || ($urandom_range(99) >= sink_stall_pct);
        end
    end

    always @(posedge aclk) begin
        outcome_t exp_o;
        data_t    got_w;
        if (aresetn && m_tvalid && m_tready) begin
            if (pending_outcomes.size() == 0) begin
                mismatch_count++;
                $display("%0t: unexpected result beat %h", $time, m_tdata);
            end else begin
                exp_o = pending_outcomes.pop_front();
                if ($signed(m_tdata[17:0]) != exp_o.sum) begin
                    mismatch_count++;
                    $display("%0t: summed_output expected %0d actual %0d", $time,
                             exp_o.sum, $signed(m_tdata[17:0]));
                end
                for (int k = 0; k < CUES; k++) begin
                    got_w = data_t'(m_tdata[18 + 16*k +: 16]);
                    if (got_w != exp_o.w[k]) begin
                        mismatch_count++;
                        $display("%0t: new_weight_%0d expected %0d actual %0d", $time, k,
                                 exp_o.w[k], got_w);
                    end
                end
            end
        end
    end

    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count > LIMIT_CYCLES) begin
            $display("CHECK FAILED");
            $finish;
        end
    end

    // ------------------------------------------------------------------------
    // stimulus
    // ------------------------------------------------------------------------
    initial begin
        dir_row_t dir_rows [N_DIR];
        trial_t   t;
        int       pick;
        int       src_pct [4];
        int       sink_pct [4];

        src_pct  = '{0, 66, 0, 33};
        sink_pct = '{0, 0, 66, 33};

        dir_rows = '{
            '{ROW_TRIAL, '{MODE_LEARN, 0, '{0, 0, 0, 0}}, 1'b1, ZERO_OUTCOME,
              REG_LEARNING_RATE, 16'h0},
            // frozen with zero weights: nothing moves whatever the inputs
            '{ROW_TRIAL, '{MODE_FREEZE, 32767, '{32767, -32768, 1, -1}}, 1'b1, ZERO_OUTCOME,
              REG_LEARNING_RATE, 16'h0},
            '{ROW_TRIAL, '{MODE_LEARN, 32767, '{32767, 32767, 32767, 32767}}, 1'b0,
              ZERO_OUTCOME, REG_LEARNING_RATE, 16'h0},
            '{ROW_TRIAL, '{MODE_LEARN, -32768, '{-32768, -32768, -32768, -32768}}, 1'b0,
              ZERO_OUTCOME, REG_LEARNING_RATE, 16'h0},
            '{ROW_TRIAL, '{MODE_LEARN_ALT, 4096, '{4096, -4096, 2048, -1}}, 1'b0,
              ZERO_OUTCOME, REG_LEARNING_RATE, 16'h0},
            '{ROW_TRIAL, '{MODE_FREEZE, 0, '{32767, -32768, -32768, 32767}}, 1'b0,
              ZERO_OUTCOME, REG_LEARNING_RATE, 16'h0},
            '{ROW_TRIAL, '{MODE_RELOAD, 0, '{0, 0, 0, 0}}, 1'b1, ZERO_OUTCOME,
              REG_LEARNING_RATE, 16'h0},
            '{ROW_REG, ZERO_TRIAL, 1'b0, ZERO_OUTCOME, REG_LEARNING_RATE, 16'h7FFF},
            '{ROW_REG, ZERO_TRIAL, 1'b0, ZERO_OUTCOME, REG_INIT_WEIGHT_0, 16'h7FFF},
            '{ROW_REG, ZERO_TRIAL, 1'b0, ZERO_OUTCOME, REG_INIT_WEIGHT_1, 16'h8000},
            '{ROW_REG, ZERO_TRIAL, 1'b0, ZERO_OUTCOME, REG_INIT_WEIGHT_2, 16'h0001},
            '{ROW_REG, ZERO_TRIAL, 1'b0, ZERO_OUTCOME, REG_INIT_WEIGHT_3, 16'hFFFF},
            '{ROW_REG, ZERO_TRIAL, 1'b0, ZERO_OUTCOME, REG_UNUSED_5, 16'hA5A5},
            // zero inputs after reload: result is just the configured weights
            '{ROW_TRIAL, '{MODE_RELOAD, 0, '{0, 0, 0, 0}}, 1'b1,
              '{0, '{32767, -32768, 1, -1}}, REG_LEARNING_RATE, 16'h0},
            '{ROW_TRIAL, '{MODE_LEARN, 32767, '{32767, 32767, 32767, 32767}}, 1'b0,
              ZERO_OUTCOME, REG_LEARNING_RATE, 16'h0},
            '{ROW_TRIAL, '{MODE_RELOAD, -32768, '{-32768, -32768, -32768, -32768}}, 1'b0,
              ZERO_OUTCOME, REG_LEARNING_RATE, 16'h0},
            '{ROW_TRIAL, '{MODE_LEARN, 32767, '{-32768, -32768, -32768, -32768}}, 1'b0,
              ZERO_OUTCOME, REG_LEARNING_RATE, 16'h0},
            '{ROW_REG, ZERO_TRIAL, 1'b0, ZERO_OUTCOME, REG_INIT_WEIGHT_1, 16'h7FFF},
            '{ROW_REG, ZERO_TRIAL, 1'b0, ZERO_OUTCOME, REG_INIT_WEIGHT_3, 16'h7FFF},
            // sum saturates high, then low
            '{ROW_TRIAL, '{MODE_RELOAD, 0, '{32767, 32767, 32767, 32767}}, 1'b0,
              ZERO_OUTCOME, REG_LEARNING_RATE, 16'h0},
            '{ROW_TRIAL, '{MODE_RELOAD, 0, '{-32768, -32768, 0, -32768}}, 1'b0,
              ZERO_OUTCOME, REG_LEARNING_RATE, 16'h0},
            '{ROW_REG, ZERO_TRIAL, 1'b0, ZERO_OUTCOME, REG_LEARNING_RATE, 16'h0000},
            '{ROW_TRIAL, '{MODE_LEARN, 12345, '{1000, -1000, 77, -77}}, 1'b0,
              ZERO_OUTCOME, REG_LEARNING_RATE, 16'h0},
            '{ROW_REG, ZERO_TRIAL, 1'b0, ZERO_OUTCOME, REG_UNUSED_6, 16'hFFFF},
            '{ROW_REG, ZERO_TRIAL, 1'b0, ZERO_OUTCOME, REG_UNUSED_7, 16'h0000},
            // bit 15 of the rate write is dropped
            '{ROW_REG, ZERO_TRIAL, 1'b0, ZERO_OUTCOME, REG_LEARNING_RATE, 16'hFFFF},
            '{ROW_TRIAL, '{MODE_LEARN, -20000, '{5000, -5000, 300, -3}}, 1'b0,
              ZERO_OUTCOME, REG_LEARNING_RATE, 16'h0},
            '{ROW_TRIAL, '{MODE_LEARN_ALT, 8000, '{-32768, 32767, -1, 1}}, 1'b0,
              ZERO_OUTCOME, REG_LEARNING_RATE, 16'h0}
        };

        aresetn        = 1'b0;
        s_tvalid       = 1'b0;
        s_tdata        = '0;
        cfg_wr_en      = 1'b0;
        cfg_index      = '0;
        cfg_wr_data    = '0;
        mismatch_count = 0;
        cycle_count    = 0;
        src_idle_pct   = 0;
        sink_stall_pct = 0;
        lr_model       = LR_RESET;
        for (int k = 0; k < CUES; k++) begin
            init_w_model[k]  = '0;
            weights_model[k] = '0;
        end

        repeat (10) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;
        @(negedge aclk);

        for (int r = 0; r < N_DIR; r++) begin
            if (dir_rows[r].kind == ROW_REG) begin
                drain_results();
                write_reg(dir_rows[r].reg_idx, dir_rows[r].reg_data);
            end else begin
                send_trial(dir_rows[r].trial, dir_rows[r].known, dir_rows[r].outcome);
            end
        end

        for (int p = 0; p < 4; p++) begin
            for (int s = 0; s < SEGS_PER_PASS; s++) begin
                drain_results();
                src_idle_pct   = src_pct[p];
                sink_stall_pct = sink_pct[p];
                case ($urandom_range(4))
                    0:       write_reg(REG_LEARNING_RATE, 16'h7FFF);
                    1:       write_reg(REG_LEARNING_RATE, 16'h0000);
                    2:       write_reg(REG_LEARNING_RATE, W_DATA'(LR_RESET));
                    3:       write_reg(REG_LEARNING_RATE, W_DATA'($urandom_range(4096)));
                    default: write_reg(REG_LEARNING_RATE, W_DATA'($urandom));
                endcase
                for (int k = 0; k < CUES; k++) begin
                    write_reg(REG_INIT_WEIGHT_0 + W_CFG_IDX'(k), rand_q412());
                end
                if ($urandom_range(1) == 1) begin
                    write_reg(REG_UNUSED_5 + W_CFG_IDX'($urandom_range(2)), W_DATA'($urandom));
                end

                for (int n = 0; n < SEG_TRIALS; n++) begin
                    pick = $urandom_range(99);
                    if (pick < 50)      t.mode = MODE_LEARN;
                    else if (pick < 65) t.mode = MODE_RELOAD;
                    else if (pick < 85) t.mode = MODE_FREEZE;
                    else                t.mode = MODE_LEARN_ALT;
                    t.target = rand_q412();
                    for (int k = 0; k < CUES; k++) t.cue[k] = rand_q412();
                    // now and then let the pipe run dry mid-segment
                    if ($urandom_range(49) == 0) drain_results();
                    send_trial(t, 1'b0, ZERO_OUTCOME);
                end
            end
        end

        drain_results();
        if (mismatch_count == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule

>>> filelist.f
+incdir+hdl
hdl/bmcl_pkg.sv
hdl/bmcl_lane.sv
hdl/bmcl_merge.sv
hdl/bush_mosteller_cue_learner_core.sv
hdl/bmcl_checker.sv
tb/sv/tb_bush_mosteller_cue_learner_core.sv
